// File: rtl/rbhd_pkg.sv
// shared types and widths for the ray versus box hit distance pipeline
// no dependencies
package rbhd_pkg;

  localparam int FW = 32;               // field width, signed q16.16
  localparam int NW = FW + 1;           // slab offset width
  localparam int QW = NW + 16;          // quotient width, 49 bits
  localparam int DW = 31;               // distance width
  localparam int PW = FW + 11;          // width of the reached point
  localparam int OW = 41;               // clamped offset width
  localparam logic [OW-1:0] OFF_CLAMP = 41'h100_0000_0000;
  localparam logic [DW-1:0] DIST_MAX = 31'h7FFF_FFFF;

  typedef logic [FW-1:0] fx_t;

  typedef struct packed {
    fx_t [2:0] org;
    fx_t [2:0] dir;
    fx_t [2:0] lo;
    fx_t [2:0] hi;
    logic [2:0] app;
    logic undef;
    logic nodir;
    logic enclosed;
  } ctx_t;

endpackage

// File: rtl/ray_box_hit_distance.sv
// throughput: one item per cycle while the output is not stalled; a 49-stage restoring
//   divider per axis, one quotient bit per stage, then a multiply stage, a slab check
//   stage and the output register
// a stalled output freezes the whole pipeline; in_stall follows it
// reset: synchronous, clears all valid bits; payload registers are not reset
// uses rbhd_pkg
module ray_box_hit_distance import rbhd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] origin_x,
  input  logic [31:0] origin_y,
  input  logic [31:0] origin_z,
  input  logic [31:0] dir_x,
  input  logic [31:0] dir_y,
  input  logic [31:0] dir_z,
  input  logic [31:0] box_min_x,
  input  logic [31:0] box_min_y,
  input  logic [31:0] box_min_z,
  input  logic [31:0] box_max_x,
  input  logic [31:0] box_max_y,
  input  logic [31:0] box_max_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        hit,
  output logic [30:0] distance
);

  logic en;

  logic vld [0:QW+2];
  ctx_t ctx [0:QW+2];

  logic [FW-1:0] rem [0:QW][3];
  logic [FW-1:0] den [0:QW][3];
  logic [QW-1:0] quo [0:QW][3];
  logic [QW-1:0] dvd [0:QW][3];

  logic [FW-1:0] rem_next [1:QW][3];
  logic [QW-1:0] quo_next [1:QW][3];

  ctx_t ctx_in;
  logic [NW-1:0] num_in [3];
  logic [FW-1:0] den_in [3];

  logic [64:0] ph [3][2];
  logic [47:0] pl [3][2];
  logic [QW-1:0] tm [3];
  logic [64:0] ph_next [3][2];
  logic [47:0] pl_next [3][2];

  logic [QW-1:0] tc [3];
  logic [2:0] ok;
  logic [2:0] ok_next;

  logic hit_next;
  logic [DW-1:0] dist_next;

  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  // input decode: approach test, slab offset, direction magnitude and the undefined, enclosed and zero-direction flags
  always_comb begin
    logic [FW:0] sh_a, sh_b;
    logic lo_side;
    ctx_in.org = {origin_z, origin_y, origin_x};
    ctx_in.dir = {dir_z, dir_y, dir_x};
    ctx_in.lo = {box_min_z, box_min_y, box_min_x};
    ctx_in.hi = {box_max_z, box_max_y, box_max_x};
    ctx_in.undef = 1'b0;
    ctx_in.enclosed = 1'b1;
    ctx_in.nodir = (dir_x == '0) && (dir_y == '0) && (dir_z == '0);
    for (int a = 0; a < 3; a++) begin
      lo_side = $signed(ctx_in.org[a]) < $signed(ctx_in.lo[a]);
      if ($signed(ctx_in.lo[a]) > $signed(ctx_in.hi[a])) begin
        ctx_in.undef = 1'b1;
      end
      if (lo_side || ($signed(ctx_in.org[a]) > $signed(ctx_in.hi[a]))) begin
        ctx_in.enclosed = 1'b0;
      end
      ctx_in.app[a] = (lo_side && !ctx_in.dir[a][FW-1] && (ctx_in.dir[a] != '0)) ||
                      ($signed(ctx_in.org[a]) > $signed(ctx_in.hi[a]) &&
                       ctx_in.dir[a][FW-1]);
      if (lo_side) begin
        sh_a = {ctx_in.lo[a][FW-1], ctx_in.lo[a]};
        sh_b = {ctx_in.org[a][FW-1], ctx_in.org[a]};
      end else begin
        sh_a = {ctx_in.org[a][FW-1], ctx_in.org[a]};
        sh_b = {ctx_in.hi[a][FW-1], ctx_in.hi[a]};
      end
      num_in[a] = sh_a - sh_b;
      den_in[a] = ctx_in.dir[a][FW-1] ? (~ctx_in.dir[a] + 1'b1) : ctx_in.dir[a];
    end
  end

  // one restoring divide step per stage
  always_comb begin
    logic [FW:0] sh;
    logic [FW+1:0] df;
    for (int j = 1; j <= QW; j++) begin
      for (int a = 0; a < 3; a++) begin
        sh = {rem[j-1][a], dvd[j-1][a][QW-1]};
        df = {1'b0, sh} - {2'b0, den[j-1][a]};
        if (!df[FW+1]) begin
          rem_next[j][a] = df[FW-1:0];
          quo_next[j][a] = {quo[j-1][a][QW-2:0], 1'b1};
        end else begin
          rem_next[j][a] = sh[FW-1:0];
          quo_next[j][a] = {quo[j-1][a][QW-2:0], 1'b0};
        end
      end
    end
  end

  // offsets on the two other axes
  always_comb begin
    int k;
    logic [FW-1:0] mag;
    for (int a = 0; a < 3; a++) begin
      for (int j = 0; j < 2; j++) begin
        k = a + j + 1;
        if (k >= 3) begin
          k = k - 3;
        end
        mag = ctx[QW].dir[k][FW-1] ? (~ctx[QW].dir[k] + 1'b1) : ctx[QW].dir[k];
        ph_next[a][j] = quo[QW][a][QW-1:16] * mag;
        pl_next[a][j] = quo[QW][a][15:0] * mag;
      end
    end
  end

  // slab check of the reached point
  always_comb begin
    int k;
    logic [65:0] prod;
    logic [OW-1:0] off;
    logic [PW-1:0] pt;
    logic [PW-1:0] lo_e, hi_e;
    for (int a = 0; a < 3; a++) begin
      ok_next[a] = ctx[QW+1].app[a];
      for (int j = 0; j < 2; j++) begin
        k = a + j + 1;
        if (k >= 3) begin
          k = k - 3;
        end
        prod = {1'b0, ph[a][j]} + {34'b0, pl[a][j][47:16]};
        if (prod > {25'b0, OFF_CLAMP}) begin
          off = OFF_CLAMP;
        end else begin
          off = prod[OW-1:0];
        end
        if (ctx[QW+1].dir[k][FW-1]) begin
          pt = {{11{ctx[QW+1].org[k][FW-1]}}, ctx[QW+1].org[k]} - {2'b0, off};
        end else begin
          pt = {{11{ctx[QW+1].org[k][FW-1]}}, ctx[QW+1].org[k]} + {2'b0, off};
        end
        lo_e = {{11{ctx[QW+1].lo[k][FW-1]}}, ctx[QW+1].lo[k]};
        hi_e = {{11{ctx[QW+1].hi[k][FW-1]}}, ctx[QW+1].hi[k]};
        if ($signed(pt) < $signed(lo_e) || $signed(pt) > $signed(hi_e)) begin
          ok_next[a] = 1'b0;
        end
      end
    end
  end

  // nearest face and special cases
  always_comb begin
    logic found;
    logic [QW-1:0] best;
    found = 1'b0;
    best = '0;
    for (int a = 0; a < 3; a++) begin
      if (ok[a] && (!found || tc[a] < best)) begin
        found = 1'b1;
        best = tc[a];
      end
    end
    if (ctx[QW+2].undef || ctx[QW+2].nodir) begin
      hit_next = 1'b0;
      dist_next = '0;
    end else if (ctx[QW+2].enclosed) begin
      hit_next = 1'b1;
      dist_next = '0;
    end else if (!found) begin
      hit_next = 1'b0;
      dist_next = '0;
    end else if (best > {{(QW-DW){1'b0}}, DIST_MAX}) begin
      hit_next = 1'b1;
      dist_next = DIST_MAX;
    end else begin
      hit_next = 1'b1;
      dist_next = best[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j <= QW + 2; j++) begin
        vld[j] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int j = 1; j <= QW + 2; j++) begin
        vld[j] <= vld[j-1];
      end
      out_valid <= vld[QW+2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx[0] <= ctx_in;
      for (int a = 0; a < 3; a++) begin
        rem[0][a] <= '0;
        quo[0][a] <= '0;
        dvd[0][a] <= {num_in[a], 16'b0};
        den[0][a] <= den_in[a];
      end
      for (int j = 1; j <= QW; j++) begin
        ctx[j] <= ctx[j-1];
        for (int a = 0; a < 3; a++) begin
          rem[j][a] <= rem_next[j][a];
          quo[j][a] <= quo_next[j][a];
          dvd[j][a] <= {dvd[j-1][a][QW-2:0], 1'b0};
          den[j][a] <= den[j-1][a];
        end
      end
      ctx[QW+1] <= ctx[QW];
      ctx[QW+2] <= ctx[QW+1];
      for (int a = 0; a < 3; a++) begin
        tm[a] <= quo[QW][a];
        tc[a] <= tm[a];
        for (int j = 0; j < 2; j++) begin
          ph[a][j] <= ph_next[a][j];
          pl[a][j] <= pl_next[a][j];
        end
      end
      ok <= ok_next;
      hit <= hit_next;
      distance <= dist_next;
    end
  end

  a_nohit_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> distance == '0)
    else $error("no-hit result with nonzero distance");

  a_last_to_out: assert property (@(posedge clk) disable iff (rst)
    vld[QW+2] && en |=> out_valid)
    else $error("item lost between check stage and output");

  a_frozen: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld[QW+2]) && $stable(vld[0]))
    else $error("pipeline moved while output stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !vld[0])
    else $error("valid bits not cleared by reset");

endmodule
